@@ rtl/macd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package macd_pkg;

    // Window geometry; the depth is a power of two so the mean is a shift
    localparam int SAMPLE_BITS  = 10;
    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
    localparam int BYTE_BITS    = 8;
    localparam int BYTE_SHIFT   = SAMPLE_BITS - BYTE_BITS;
    localparam int BYTE_ROUND   = (1 << BYTE_SHIFT) >> 1;
    localparam int CFG_IDX_BITS = 2;

    // Register defaults, also stored when zero is written
    localparam logic [BYTE_BITS-1:0] THRESH_DEFAULT  = BYTE_BITS'(8);
    localparam logic [BYTE_BITS-1:0] HOLDOFF_DEFAULT = BYTE_BITS'(10);

    // Request kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HOLDOFF   = 2'd1,
        REG_IRQ_EN    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic [BYTE_BITS-1:0]   average_byte;
        logic                   interrupt_raised;
        logic                   holdoff_running;
    } out_item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] threshold;
        logic [BYTE_BITS-1:0] holdoff;
        logic                 irq_en;
    } cfg_t;

    // Request handed to the update stage
    typedef struct packed {
        logic                   commit;   // stage advances this cycle with a request
        logic                   tick;     // timer tick instead of a sample
        logic                   wrapped;  // window entry has been written before
        logic [SAMPLE_BITS-1:0] sample;
    } upd_req_t;

    // Rounded mean of the window, (sum + depth/2) / depth
    function automatic logic [SAMPLE_BITS-1:0] window_mean(input logic [SUM_BITS-1:0] sum);
        logic [SUM_BITS:0] r;
        r = {1'b0, sum} + (SUM_BITS + 1)'(WINDOW_DEPTH / 2);
        return r[SLOT_BITS +: SAMPLE_BITS];
    endfunction

    // Average scaled to a byte with round-half-up, saturating
    function automatic logic [BYTE_BITS-1:0] to_byte(input logic [SAMPLE_BITS-1:0] avg);
        logic [SAMPLE_BITS:0] r;
        r = ({1'b0, avg} + (SAMPLE_BITS + 1)'(BYTE_ROUND)) >> BYTE_SHIFT;
        if (r > (SAMPLE_BITS + 1)'(255))
            return {BYTE_BITS{1'b1}};
        else
            return r[BYTE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/moving_average_change_detector.sv @@
// Moving average of the last 16 converter samples with a change interrupt. Each request
// is a sample or a timer tick and gives exactly one result: the rounded window mean, its
// byte-scaled form, whether this sample raised an interrupt, and whether the holdoff is
// running. The window sits in a one-read, one-write memory with a registered read: a
// request reads its window slot in the first stage, and the second stage subtracts the
// old entry, adds the new one, writes it back and checks the change threshold. A request
// can be taken every cycle unless the output stalls; it passes stage 1, stage 2 and the
// output register, and a stalled result holds the whole pipe and the input. The first sample
// after reset fills the whole window with its own value. Configuration writes are taken
// at any time but must only be issued while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_change_detector
    import macd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire in_item_t                in_data,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output out_item_t                    out_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [BYTE_BITS-1:0]    cfg_data
);

    logic                 adv;
    logic                 in_acc;

    cfg_t                 cfg_reg;

    logic [SLOT_BITS-1:0] slot_reg,    slot_next;
    logic                 wrapped_reg, wrapped_next;

    logic                 s1_valid_reg;
    in_item_t             s1_item_reg;
    logic [SLOT_BITS-1:0] s1_slot_reg;
    logic                 s1_wrapped_reg;

    logic                 s2_valid_reg;
    in_item_t             s2_item_reg;
    logic [SLOT_BITS-1:0] s2_slot_reg;
    logic                 s2_wrapped_reg;

    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   wr_en;
    upd_req_t               req;
    out_item_t              result;

    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    // Whole pipe moves unless a finished result is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign in_acc   = in_valid && adv;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THRESH_DEFAULT;
            cfg_reg.holdoff   <= HOLDOFF_DEFAULT;
            cfg_reg.irq_en    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:
                begin
                    cfg_reg.threshold <= (cfg_data == '0) ? THRESH_DEFAULT : cfg_data;
                end
                REG_HOLDOFF:
                begin
                    cfg_reg.holdoff <= (cfg_data == '0) ? HOLDOFF_DEFAULT : cfg_data;
                end
                REG_IRQ_EN:
                begin
                    cfg_reg.irq_en <= cfg_data[0];
                end
                default:
                begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // Write slot and fill tracking; entries fill in slot order
    always_comb
    begin
        slot_next    = slot_reg;
        wrapped_next = wrapped_reg;
        if (in_acc && in_data.mode == MODE_SAMPLE)
        begin
            if (slot_reg == SLOT_BITS'(WINDOW_DEPTH - 1))
            begin
                slot_next    = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            slot_reg    <= slot_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg    <= in_data;
            s1_slot_reg    <= slot_reg;
            s1_wrapped_reg <= wrapped_reg;
            s2_item_reg    <= s1_item_reg;
            s2_slot_reg    <= s1_slot_reg;
            s2_wrapped_reg <= s1_wrapped_reg;
            out_data_reg   <= result;
        end
    end

    // Window memory: stage 1 reads its slot, stage 2 writes it back
    assign wr_en = adv && s2_valid_reg && s2_item_reg.mode == MODE_SAMPLE;

    macd_window_ram #(
        .DATA_BITS (SAMPLE_BITS),
        .ADDR_BITS (SLOT_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s2_slot_reg),
        .wr_data (s2_item_reg.sample),
        .rd_en   (adv),
        .rd_addr (s1_slot_reg),
        .rd_data (rd_data)
    );

    // Update stage
    assign req.commit  = adv && s2_valid_reg;
    assign req.tick    = (s2_item_reg.mode == MODE_TICK);
    assign req.wrapped = s2_wrapped_reg;
    assign req.sample  = s2_item_reg.sample;

    macd_update u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .old_data (rd_data),
        .cfg      (cfg_reg),
        .result   (result)
    );

    // Read and write of the same entry never overlap in the pipe
    a_no_slot_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s1_item_reg.mode == MODE_SAMPLE
         && s2_item_reg.mode == MODE_SAMPLE) |-> (s1_slot_reg != s2_slot_reg))
        else $error("window read and write hit the same slot");

    // An accepted request lands in stage 1
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted request lost at stage 1");

    // Once the window has been filled it stays filled
    a_wrapped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(wrapped_reg))
        else $error("window fill flag cleared");

    // A result only appears from a valid update stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result without a request in the update stage");

endmodule

`default_nettype wire

@@ rtl/macd_window_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module macd_window_ram #(
    parameter int DATA_BITS = 10,
    parameter int ADDR_BITS = 4
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/macd_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

module macd_update
    import macd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire upd_req_t               req,
    input  wire logic [SAMPLE_BITS-1:0] old_data,
    input  wire cfg_t                   cfg,
    output out_item_t                   result
);

    logic [SUM_BITS-1:0]    sum_reg,     sum_next;
    logic [SAMPLE_BITS-1:0] prime_reg,   prime_next;
    logic                   primed_reg,  primed_next;
    logic [SAMPLE_BITS-1:0] level_reg,   level_next;
    logic [BYTE_BITS-1:0]   holdoff_reg, holdoff_next;

    logic [SUM_BITS-1:0]    sum_base;
    logic [SAMPLE_BITS-1:0] prime_eff;
    logic [SAMPLE_BITS-1:0] level_eff;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   raise;

    // Running sum, priming and change detection
    always_comb
    begin
        sum_next     = sum_reg;
        prime_next   = prime_reg;
        primed_next  = primed_reg;
        level_next   = level_reg;
        holdoff_next = holdoff_reg;
        raise        = 1'b0;

        // first sample fills the whole window with itself
        sum_base  = primed_reg ? sum_reg : {req.sample, {SLOT_BITS{1'b0}}};
        prime_eff = primed_reg ? prime_reg : req.sample;
        level_eff = primed_reg ? level_reg : req.sample;
        old_val   = req.wrapped ? old_data : prime_eff;

        if (req.tick)
        begin
            avg = primed_reg ? window_mean(sum_reg) : '0;
            if (holdoff_reg != '0)
            begin
                holdoff_next = holdoff_reg - 1'b1;
            end
        end
        else
        begin
            sum_next    = sum_base - SUM_BITS'(old_val) + SUM_BITS'(req.sample);
            prime_next  = prime_eff;
            primed_next = 1'b1;
            avg         = window_mean(sum_next);
            level_next  = level_eff;
        end

        diff = (level_eff >= avg) ? level_eff - avg : avg - level_eff;

        if (!req.tick && holdoff_reg == '0 && cfg.irq_en
            && diff > SAMPLE_BITS'(cfg.threshold))
        begin
            raise        = 1'b1;
            holdoff_next = cfg.holdoff;
            level_next   = avg;
        end

        result.average          = avg;
        result.average_byte     = to_byte(avg);
        result.interrupt_raised = raise;
        result.holdoff_running  = (holdoff_next != '0);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            prime_reg   <= '0;
            primed_reg  <= 1'b0;
            level_reg   <= '0;
            holdoff_reg <= '0;
        end
        else if (req.commit)
        begin
            sum_reg     <= sum_next;
            prime_reg   <= prime_next;
            primed_reg  <= primed_next;
            level_reg   <= level_next;
            holdoff_reg <= holdoff_next;
        end
    end

endmodule

`default_nettype wire
